@@ src/rcfd_pkg.sv @@
// Shared constants and control types for the RC receiver frame decoder.
`default_nettype none
package rcfd_pkg;

	localparam int FRAME_LENGTH_DEF  = 32;
	localparam int CHANNEL_COUNT_DEF = 14;

	localparam logic [7:0]  HDR_FIRST   = 8'h20;
	localparam logic [7:0]  HDR_SECOND  = 8'h40;
	localparam logic [15:0] CSUM_INIT   = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RST = 16'd100;
	localparam logic [31:0] AGE_MAX     = 32'hFFFF_FFFF;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_CHANNEL = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic accept;     // input beat taken this cycle
		logic rd_first;   // start channel run
		logic rd_next;    // channel beat taken, fetch next
		logic show_chan;  // output shows a channel value
	} rcfd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic frame_good; // current byte completes a good frame
		logic last_chan;  // channel on show is the last of the run
	} rcfd_sts_t;

endpackage
`default_nettype wire

@@ src/rcfd_channels.sv @@
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface rcfd_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, action, rx_byte, input ready);
	modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface rcfd_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [3:0]  channel_index;
	logic [15:0] channel_value;
	logic        last_of_run;
	logic        checksum_error;
	logic        online;
	logic [31:0] frame_total;

	modport source (output valid, kind, channel_index, channel_value, last_of_run,
		checksum_error, online, frame_total, input ready);
	modport sink   (input valid, kind, channel_index, channel_value, last_of_run,
		checksum_error, online, frame_total, output ready);
endinterface
`default_nettype wire

@@ src/rc_receiver_frame_decoder_top.sv @@
// Top level of the RC receiver frame decoder: controller, datapath and ports.
// Usage:
//   item   : input beats, action 0 = received serial byte in rx_byte,
//            action 1 = one millisecond tick.
//   result : result beats. Every input beat gives one status beat, except a
//            byte that completes a frame with a good checksum, which gives a
//            run of CHANNEL_COUNT channel beats, last_of_run on the final one.
//   cfg_we/cfg_wdata : write the link timeout in ms; write only while idle.
// Timing: a status beat is shown the cycle after its input beat is taken.
//   A good frame's run starts after the last byte with ST_READ, which fetches
//   the first byte pair from the frame store, then ST_EMIT shows one channel
//   per cycle while result.ready is high. The frame store has one read port,
//   which sets the one-channel-per-cycle pace. A new input beat is taken in
//   the same cycle its status beat leaves.
// Stall: while result.ready is low a shown beat holds and no input beat is
//   taken until it leaves.
// Reset: arst_n clears framing, link state and frame count; the link timeout
//   returns to 100 ms. The frame store is not cleared: every word a check or a
//   channel reads was written by the frame itself.
`default_nettype none
module rc_receiver_frame_decoder_top #(
	parameter int FRAME_LENGTH  = rcfd_pkg::FRAME_LENGTH_DEF,
	parameter int CHANNEL_COUNT = rcfd_pkg::CHANNEL_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	rcfd_in_if.sink          item,
	rcfd_out_if.source       result,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);
	import rcfd_pkg::*;

	rcfd_cmd_t cmd;
	rcfd_sts_t sts;

	// state machine: handshakes and run sequencing
	rcfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_action (item.action),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: framing, checksum, store and result payload
	rcfd_datapath #(
		.FRAME_LENGTH  (FRAME_LENGTH),
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.action         (item.action),
		.rx_byte        (item.rx_byte),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.kind           (result.kind),
		.channel_index  (result.channel_index),
		.channel_value  (result.channel_value),
		.last_of_run    (result.last_of_run),
		.checksum_error (result.checksum_error),
		.online         (result.online),
		.frame_total    (result.frame_total)
	);
endmodule
`default_nettype wire

@@ src/rcfd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rcfd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ src/rcfd_datapath.sv @@
// Datapath: framing, running checksum, frame store, link supervision, result payload.
`default_nettype none
module rcfd_datapath #(
	parameter int FRAME_LENGTH  = rcfd_pkg::FRAME_LENGTH_DEF,
	parameter int CHANNEL_COUNT = rcfd_pkg::CHANNEL_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rcfd_pkg::rcfd_cmd_t cmd,
	output rcfd_pkg::rcfd_sts_t      sts,
	input  wire logic                action,
	input  wire logic [7:0]          rx_byte,
	input  wire logic                cfg_we,
	input  wire logic [15:0]         cfg_wdata,
	output logic                     kind,
	output logic [3:0]               channel_index,
	output logic [15:0]              channel_value,
	output logic                     last_of_run,
	output logic                     checksum_error,
	output logic                     online,
	output logic [31:0]              frame_total
);
	import rcfd_pkg::*;

	localparam int PW    = $clog2(FRAME_LENGTH);
	localparam int WORDS = (FRAME_LENGTH + 1) / 2;
	localparam int AW    = $clog2(WORDS);
	localparam int CW    = $clog2(CHANNEL_COUNT + 2);

	logic [PW-1:0] pos_q;
	logic [15:0]   sum_q;
	logic [7:0]    chk_lo_q;
	logic [7:0]    even_q;
	logic          valid_q;
	logic [31:0]   age_q;
	logic [31:0]   count_q;
	logic [15:0]   timeout_q;
	logic          cerr_q;
	logic [CW-1:0] chan_q;
	logic          zero_q;

	logic          is_byte, rej_first, rej_second, store, at_last, at_chk_lo;
	logic          good, bad;
	logic [15:0]   rx_sum;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [CW-1:0] chan_nxt;
	logic [CW-1:0] word_nxt;
	logic          word_ok;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	assign is_byte    = (action == ACT_BYTE);
	assign rej_first  = (pos_q == '0) && (rx_byte != HDR_FIRST);
	assign rej_second = (pos_q == PW'(1)) && (rx_byte != HDR_SECOND);
	assign store      = is_byte && !rej_first && !rej_second;
	assign at_last    = (pos_q == PW'(FRAME_LENGTH - 1));
	assign at_chk_lo  = (pos_q == PW'(FRAME_LENGTH - 2));
	assign rx_sum     = {rx_byte, chk_lo_q};
	assign good       = store && at_last && (sum_q == rx_sum);
	assign bad        = store && at_last && (sum_q != rx_sum);

	// frame store holds byte pairs; an odd-length frame's last byte sits alone
	assign ram_we    = cmd.accept && store && (pos_q[0] || at_last);
	assign ram_waddr = AW'(pos_q >> 1);
	assign ram_wdata = pos_q[0] ? {rx_byte, even_q} : {8'h00, rx_byte};

	// channel i lives in word i+1; words past the frame read as zero
	assign chan_nxt  = cmd.rd_first ? '0 : CW'(chan_q + CW'(1));
	assign word_nxt  = CW'(chan_nxt + CW'(1));
	assign word_ok   = (32'(word_nxt) < 32'(WORDS));
	assign ram_re    = cmd.rd_first || cmd.rd_next;
	assign ram_raddr = word_ok ? AW'(word_nxt) : '0;

	rcfd_ram #(.WIDTH(16), .DEPTH(WORDS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			valid_q   <= 1'b0;
			age_q     <= '0;
			count_q   <= '0;
			timeout_q <= TIMEOUT_RST;
			cerr_q    <= 1'b0;
			chan_q    <= '0;
			zero_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				cerr_q <= bad;
				if (!is_byte) begin
					if (age_q != AGE_MAX) begin
						age_q <= age_q + 32'd1;
					end
				end else if (rej_second) begin
					pos_q <= '0;
				end else if (store) begin
					pos_q <= at_last ? '0 : PW'(pos_q + PW'(1));
					if (good) begin
						valid_q <= 1'b1;
						age_q   <= '0;
						count_q <= count_q + 32'd1;
					end
				end
			end
			if (ram_re) begin
				chan_q <= chan_nxt;
				zero_q <= !word_ok;
			end
		end
	end

	// payload-only registers
	always_ff @(posedge clk) begin
		if (cmd.accept && store) begin
			if (pos_q == '0) begin
				sum_q <= CSUM_INIT - {8'h00, rx_byte};
			end else if (32'(pos_q) < 32'(FRAME_LENGTH - 2)) begin
				sum_q <= sum_q - {8'h00, rx_byte};
			end
			if (at_chk_lo) begin
				chk_lo_q <= rx_byte;
			end
			if (!pos_q[0]) begin
				even_q <= rx_byte;
			end
		end
	end

	assign sts.frame_good = good;
	assign sts.last_chan  = (chan_q == CW'(CHANNEL_COUNT - 1));

	assign kind           = cmd.show_chan ? KIND_CHANNEL : KIND_STATUS;
	assign channel_index  = cmd.show_chan ? 4'(chan_q) : 4'd0;
	assign channel_value  = (cmd.show_chan && !zero_q) ? ram_rdata : 16'd0;
	assign last_of_run    = cmd.show_chan ? sts.last_chan : 1'b1;
	assign checksum_error = cmd.show_chan ? 1'b0 : cerr_q;
	assign online         = valid_q && (age_q < {16'd0, timeout_q});
	assign frame_total    = count_q;
endmodule
`default_nettype wire

@@ src/rcfd_ctrl.sv @@
// Controller: sequences status beats and the channel run.
`default_nettype none
module rcfd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                in_action,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire rcfd_pkg::rcfd_sts_t sts,
	output rcfd_pkg::rcfd_cmd_t      cmd
);
	import rcfd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_STATUS = 4'b0010,
		ST_READ   = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   in_fire;

	assign in_ready  = (state_q == ST_IDLE) || ((state_q == ST_STATUS) && out_ready);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (state_q == ST_STATUS) || (state_q == ST_EMIT);

	assign cmd.accept    = in_fire;
	assign cmd.rd_first  = (state_q == ST_READ);
	assign cmd.rd_next   = (state_q == ST_EMIT) && out_ready && !sts.last_chan;
	assign cmd.show_chan = (state_q == ST_EMIT);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_STATUS: begin
				if (in_fire) begin
					state_d = (in_action == ACT_BYTE && sts.frame_good) ? ST_READ : ST_STATUS;
				end else if (state_q == ST_STATUS && out_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready && sts.last_chan) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_accept_during_run: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && (cmd.rd_first || cmd.rd_next)))
		else $error("input beat taken during channel run");

	a_read_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_EMIT))
		else $error("channel fetch not followed by emit");

	a_run_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_ready && sts.last_chan) |=> (state_q == ST_IDLE))
		else $error("channel run did not end after last beat");

	a_good_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_action == ACT_BYTE && sts.frame_good) |=> (state_q == ST_READ))
		else $error("good frame did not start a channel run");
endmodule
`default_nettype wire
